[rtl/core/hrp_pkg.sv]
// Shared types, codes and match strings for the HTTP request header parser.
// No dependencies; imported by every module of the block.
package hrp_pkg;

  localparam int FQ_DEPTH = 4;
  localparam int FQ_AW    = $clog2(FQ_DEPTH);
  localparam int RQ_DEPTH = 2;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD       = 2'd1;
  localparam logic [1:0] ST_NOT_ALLOW = 2'd2;
  localparam logic [1:0] ST_TOO_LARGE = 2'd3;

  localparam logic [1:0] MK_GET   = 2'd0;
  localparam logic [1:0] MK_HEAD  = 2'd1;
  localparam logic [1:0] MK_OTHER = 2'd2;
  localparam logic [1:0] MK_NOREQ = 2'd3;

  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_QMARK = 8'h3f;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_H     = 8'h48;

  // classified byte, as queued between front and back
  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic [7:0] fold;
    logic       lf;
    logic       cr;
    logic       sp;
    logic       ws;
    logic       qmark;
    logic       slash;
    logic       colon;
  } hrp_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  method_kind;
    logic        is_http11;
    logic        keep_conn;
    logic [10:0] path_length;
    logic        path_is_root;
  } hrp_result_t;

  function automatic logic [7:0] fold_char(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5a) return c | 8'h20;
    return c;
  endfunction

  // match strings, already lower case where compared folded
  function automatic logic [7:0] conn_char(input logic [3:0] i);
    case (i)
      4'd0: return "c";
      4'd1: return "o";
      4'd2: return "n";
      4'd3: return "n";
      4'd4: return "e";
      4'd5: return "c";
      4'd6: return "t";
      4'd7: return "i";
      4'd8: return "o";
      4'd9: return "n";
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] keep_char(input logic [3:0] i);
    case (i)
      4'd0: return "k";
      4'd1: return "e";
      4'd2: return "e";
      4'd3: return "p";
      4'd4: return "-";
      4'd5: return "a";
      4'd6: return "l";
      4'd7: return "i";
      4'd8: return "v";
      4'd9: return "e";
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] close_char(input logic [3:0] i);
    case (i)
      4'd0: return "c";
      4'd1: return "l";
      4'd2: return "o";
      4'd3: return "s";
      4'd4: return "e";
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] ver_char(input logic [3:0] i);
    case (i)
      4'd0: return "h";
      4'd1: return "t";
      4'd2: return "t";
      4'd3: return "p";
      4'd4: return "/";
      4'd5: return "1";
      4'd6: return ".";
      4'd7: return "1";
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] get_char(input logic [3:0] i);
    case (i)
      4'd0: return "G";
      4'd1: return "E";
      4'd2: return "T";
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] head_char(input logic [3:0] i);
    case (i)
      4'd0: return "H";
      4'd1: return "E";
      4'd2: return "A";
      4'd3: return "D";
      default: return 8'h00;
    endcase
  endfunction

endpackage

[rtl/core/hrp_front.sv]
// Front end: accepts input items, classifies each byte and queues it.
// Depends on hrp_pkg.
module hrp_front import hrp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  logic      in_op,
  input  logic [7:0] in_data_byte,
  output logic      item_valid,
  output hrp_item_t item,
  input  logic      item_take
);

  hrp_item_t        q_mem [FQ_DEPTH];
  logic [FQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FQ_AW:0]   count_r, count_nxt;
  logic             wr_en;
  logic             rd_en;
  hrp_item_t        cls;

  always_comb begin
    cls.op    = in_op;
    cls.data  = in_data_byte;
    cls.fold  = fold_char(in_data_byte);
    cls.lf    = (in_data_byte == CH_LF);
    cls.cr    = (in_data_byte == CH_CR);
    cls.sp    = (in_data_byte == CH_SP);
    cls.ws    = (in_data_byte == CH_SP) || (in_data_byte == CH_TAB);
    cls.qmark = (in_data_byte == CH_QMARK);
    cls.slash = (in_data_byte == CH_SLASH);
    cls.colon = (in_data_byte == CH_COLON);
  end

  assign full       = (count_r == (FQ_AW+1)'(FQ_DEPTH));
  assign item_valid = (count_r != '0);
  assign item       = q_mem[rd_ptr_r];
  assign wr_en      = push && !full;
  assign rd_en      = item_take && item_valid;

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en && !rd_en) count_nxt = count_r + 1'b1;
    else if (!wr_en && rd_en) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) q_mem[wr_ptr_r] <= cls;
  end

endmodule

[rtl/core/hrp_parser.sv]
// Back end: per-byte request line and header parser, connection state and
// the request limit register. Depends on hrp_pkg.
module hrp_parser import hrp_pkg::*; #(
  parameter int HEADER_BUF_MAX = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        item_valid,
  input  hrp_item_t   item,
  output logic        item_take,
  input  logic        rq_full,
  output logic        res_push,
  output hrp_result_t res
);

  localparam int FILL_W = $clog2(HEADER_BUF_MAX);
  localparam logic [FILL_W-1:0] FILL_LIMIT = FILL_W'(HEADER_BUF_MAX - 2);

  localparam logic [2:0] PH_METHOD  = 3'd0;
  localparam logic [2:0] PH_PATH    = 3'd1;
  localparam logic [2:0] PH_VERSION = 3'd2;
  localparam logic [2:0] PH_NAME    = 3'd3;
  localparam logic [2:0] PH_SKIP    = 3'd4;
  localparam logic [2:0] PH_VALUE   = 3'd5;
  localparam logic [2:0] PH_VEND    = 3'd6;
  localparam logic [2:0] PH_DONE    = 3'd7;

  logic [15:0]       max_req_r, max_req_nxt;
  logic [15:0]       req_cnt_r, req_cnt_nxt;
  logic              closed_r, closed_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [2:0]        phase_r, phase_nxt;
  logic [3:0]        mpos_r, mpos_nxt;
  logic [1:0]        mcode_r, mcode_nxt;
  logic              ver_ok_r, ver_ok_nxt;
  logic [11:0]       path_r, path_nxt;
  logic              root_r, root_nxt;
  logic              query_r, query_nxt;
  logic              hdr_r, hdr_nxt;
  logic              close_m_r, close_m_nxt;
  logic              keep_m_r, keep_m_nxt;
  logic [3:0]        vlen_r, vlen_nxt;
  logic [3:0]        line_r, line_nxt;
  logic [2:0]        rec_lf_r, rec_lf_nxt;
  logic [2:0]        rec_cr_r, rec_cr_nxt;

  logic              do_value;
  logic              do_clear;
  logic              term;
  logic              ka;

  assign item_take = item_valid && !rq_full;

  always_comb begin
    max_req_nxt = cfg_we ? cfg_wdata : max_req_r;
    req_cnt_nxt = req_cnt_r;
    closed_nxt  = closed_r;
    fill_nxt    = fill_r;
    phase_nxt   = phase_r;
    mpos_nxt    = mpos_r;
    mcode_nxt   = mcode_r;
    ver_ok_nxt  = ver_ok_r;
    path_nxt    = path_r;
    root_nxt    = root_r;
    query_nxt   = query_r;
    hdr_nxt     = hdr_r;
    close_m_nxt = close_m_r;
    keep_m_nxt  = keep_m_r;
    vlen_nxt    = vlen_r;
    line_nxt    = line_r;
    rec_lf_nxt  = rec_lf_r;
    rec_cr_nxt  = rec_cr_r;
    do_value    = 1'b0;
    do_clear    = 1'b0;
    term        = 1'b0;
    ka          = 1'b0;
    res_push    = 1'b0;
    res         = '0;

    if (item_take) begin
      if (item.op) begin
        do_clear    = 1'b1;
        req_cnt_nxt = '0;
        closed_nxt  = 1'b0;
      end else if (!closed_r) begin
        case (phase_r)
          PH_METHOD: begin
            if (item.lf) begin
              mcode_nxt = MK_NOREQ;
              phase_nxt = PH_NAME;
              line_nxt  = '0;
              mpos_nxt  = '0;
            end else if (item.sp) begin
              if (mcode_r == MK_GET && mpos_r != 4'd3) mcode_nxt = MK_OTHER;
              if (mcode_r == MK_HEAD && mpos_r != 4'd4) mcode_nxt = MK_OTHER;
              phase_nxt = PH_PATH;
              mpos_nxt  = '0;
            end else begin
              if (mpos_r == '0) begin
                mcode_nxt = (item.data == CH_G) ? MK_GET :
                            (item.data == CH_H) ? MK_HEAD : MK_OTHER;
              end else if (mcode_r == MK_GET) begin
                if (mpos_r >= 4'd3 || item.data != get_char(mpos_r)) mcode_nxt = MK_OTHER;
              end else if (mcode_r == MK_HEAD) begin
                if (mpos_r >= 4'd4 || item.data != head_char(mpos_r)) mcode_nxt = MK_OTHER;
              end
              if (mpos_r != 4'd15) mpos_nxt = mpos_r + 4'd1;
            end
          end
          PH_PATH: begin
            if (item.lf) begin
              // CR of a CR LF line end is not path
              if (rec_cr_r[0] && !query_r && path_r != '0) path_nxt = path_r - 12'd1;
              phase_nxt = PH_NAME;
              line_nxt  = '0;
              mpos_nxt  = '0;
            end else if (item.sp) begin
              phase_nxt = PH_VERSION;
              mpos_nxt  = '0;
            end else if (!query_r) begin
              if (item.qmark) begin
                query_nxt = 1'b1;
              end else begin
                if (path_r == '0) root_nxt = item.slash;
                if (path_r != 12'hfff) path_nxt = path_r + 12'd1;
              end
            end
          end
          PH_VERSION: begin
            if (item.lf) begin
              phase_nxt = PH_NAME;
              line_nxt  = '0;
              mpos_nxt  = '0;
            end else if (mpos_r < 4'd8) begin
              if (item.fold == ver_char(mpos_r)) begin
                mpos_nxt = mpos_r + 4'd1;
                if (mpos_r == 4'd7) ver_ok_nxt = 1'b1;
              end else begin
                mpos_nxt = 4'd15;
              end
            end
          end
          PH_NAME: begin
            if (item.lf) begin
              if (line_r == '0 || (line_r == 4'd1 && rec_cr_r[0])) begin
                phase_nxt = PH_DONE;
              end else begin
                line_nxt = '0;
                mpos_nxt = '0;
              end
            end else begin
              if (line_r < 4'd10) begin
                if (mpos_r == line_r && item.fold == conn_char(line_r))
                  mpos_nxt = mpos_r + 4'd1;
              end else if (line_r == 4'd10) begin
                if (mpos_r == 4'd10 && item.colon) mpos_nxt = 4'd11;
              end else if (line_r == 4'd11 && mpos_r == 4'd11) begin
                hdr_nxt     = 1'b1;
                close_m_nxt = 1'b1;
                keep_m_nxt  = 1'b1;
                vlen_nxt    = '0;
                phase_nxt   = PH_SKIP;
                do_value    = 1'b1;
              end
              if (line_r != 4'd15) line_nxt = line_r + 4'd1;
            end
          end
          PH_SKIP, PH_VALUE, PH_VEND: begin
            if (item.lf) begin
              if (vlen_r < 4'd10) keep_m_nxt = 1'b0;
              phase_nxt = PH_DONE;
            end else begin
              do_value = 1'b1;
            end
          end
          default: begin
          end
        endcase

        if (do_value) begin
          if (phase_nxt == PH_SKIP && !item.ws) phase_nxt = PH_VALUE;
          if (phase_nxt == PH_VALUE) begin
            if (item.cr) begin
              if (vlen_nxt < 4'd10) keep_m_nxt = 1'b0;
              phase_nxt = PH_VEND;
            end else begin
              if (vlen_nxt < 4'd5 && item.fold != close_char(vlen_nxt)) close_m_nxt = 1'b0;
              if (vlen_nxt < 4'd10 && item.fold != keep_char(vlen_nxt)) keep_m_nxt = 1'b0;
              if (vlen_nxt != 4'd15) vlen_nxt = vlen_nxt + 4'd1;
            end
          end
        end

        // LF LF or CR LF CR LF
        term = item.lf && (rec_lf_r[0] || (rec_cr_r[0] && rec_lf_r[1] && rec_cr_r[2]));
        rec_lf_nxt = {rec_lf_r[1:0], item.lf};
        rec_cr_nxt = {rec_cr_r[1:0], item.cr};
        fill_nxt   = fill_r + 1'b1;

        if (term) begin
          if (mcode_nxt == MK_NOREQ) begin
            res.status = ST_BAD;
            ka         = 1'b0;
          end else begin
            ka = ver_ok_nxt ? !(hdr_nxt && close_m_nxt) : (hdr_nxt && keep_m_nxt);
            if (({1'b0, req_cnt_r} + 17'd1) >= {1'b0, max_req_r}) ka = 1'b0;
            res.is_http11 = ver_ok_nxt;
            if (mcode_nxt == MK_OTHER) begin
              res.status      = ST_NOT_ALLOW;
              res.method_kind = MK_OTHER;
            end else begin
              res.status       = ST_OK;
              res.method_kind  = mcode_nxt;
              res.path_length  = (path_nxt > 12'd2047) ? 11'd2047 : path_nxt[10:0];
              res.path_is_root = root_nxt && !query_nxt && (path_nxt == 12'd1);
            end
          end
          res.keep_conn = ka;
          res_push      = 1'b1;
          if (req_cnt_r != 16'hffff) req_cnt_nxt = req_cnt_r + 16'd1;
          if (!ka) closed_nxt = 1'b1;
          do_clear = 1'b1;
        end else if (fill_r == FILL_LIMIT) begin
          res.status = ST_TOO_LARGE;
          res_push   = 1'b1;
          closed_nxt = 1'b1;
          do_clear   = 1'b1;
        end
      end
    end

    if (do_clear) begin
      fill_nxt    = '0;
      phase_nxt   = PH_METHOD;
      mpos_nxt    = '0;
      mcode_nxt   = MK_GET;
      ver_ok_nxt  = 1'b0;
      path_nxt    = '0;
      root_nxt    = 1'b0;
      query_nxt   = 1'b0;
      hdr_nxt     = 1'b0;
      close_m_nxt = 1'b0;
      keep_m_nxt  = 1'b0;
      vlen_nxt    = '0;
      line_nxt    = '0;
      rec_lf_nxt  = '0;
      rec_cr_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_req_r <= 16'd100;
      req_cnt_r <= '0;
      closed_r  <= 1'b0;
      fill_r    <= '0;
      phase_r   <= PH_METHOD;
      mpos_r    <= '0;
      mcode_r   <= MK_GET;
      ver_ok_r  <= 1'b0;
      path_r    <= '0;
      root_r    <= 1'b0;
      query_r   <= 1'b0;
      hdr_r     <= 1'b0;
      close_m_r <= 1'b0;
      keep_m_r  <= 1'b0;
      vlen_r    <= '0;
      line_r    <= '0;
      rec_lf_r  <= '0;
      rec_cr_r  <= '0;
    end else begin
      max_req_r <= max_req_nxt;
      req_cnt_r <= req_cnt_nxt;
      closed_r  <= closed_nxt;
      fill_r    <= fill_nxt;
      phase_r   <= phase_nxt;
      mpos_r    <= mpos_nxt;
      mcode_r   <= mcode_nxt;
      ver_ok_r  <= ver_ok_nxt;
      path_r    <= path_nxt;
      root_r    <= root_nxt;
      query_r   <= query_nxt;
      hdr_r     <= hdr_nxt;
      close_m_r <= close_m_nxt;
      keep_m_r  <= keep_m_nxt;
      vlen_r    <= vlen_nxt;
      line_r    <= line_nxt;
      rec_lf_r  <= rec_lf_nxt;
      rec_cr_r  <= rec_cr_nxt;
    end
  end

endmodule

[rtl/core/hrp_rslt_q.sv]
// Result queue: holds finished result items until the receiver pops them.
// Depends on hrp_pkg.
module hrp_rslt_q import hrp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        res_push,
  input  hrp_result_t res,
  output logic        rq_full,
  output logic        empty,
  input  logic        pop,
  output hrp_result_t head
);

  hrp_result_t      q_mem [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RQ_AW:0]   count_r, count_nxt;
  logic             wr_en;
  logic             rd_en;

  assign rq_full = (count_r == (RQ_AW+1)'(RQ_DEPTH));
  assign empty   = (count_r == '0);
  assign head    = q_mem[rd_ptr_r];
  assign wr_en   = res_push && !rq_full;
  assign rd_en   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en && !rd_en) count_nxt = count_r + 1'b1;
    else if (!wr_en && rd_en) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) q_mem[wr_ptr_r] <= res;
  end

endmodule

[rtl/core/http_request_header_parser_top.sv]
// HTTP/1.1 request header parser, top level.
// Instantiates hrp_front, hrp_parser and hrp_rslt_q; depends on hrp_pkg.
//
// Usage:
//   Input queue: drive in_op/in_data_byte and raise push; the item is taken
//   at an edge where full is low. op 0 is a request byte, op 1 starts a new
//   connection (clears parser and request count, gives no result).
//   Result queue: while empty is low the oldest result is on out_*; raise
//   pop to take it. A result comes at a header terminator or when the byte
//   limit (HEADER_BUF_MAX-1 bytes without terminator) is reached.
//   Config: cfg_we/cfg_wdata write the request limit (reset 100) at once.
// Timing:
//   One byte per cycle sustained while the result queue has room. A byte is
//   written to a 4-entry queue and handled by the parser while at its head;
//   its result is registered into the result queue and then shows on out_*.
//   The parser takes one byte per cycle while the 2-entry result queue has
//   room; if the receiver stalls, that queue fills, then the input queue
//   fills and full rises.
// Reset: synchronous rst_n clears both queues and the parser state.
module http_request_header_parser_top import hrp_pkg::*; #(
  parameter int HEADER_BUF_MAX = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_op,
  input  logic [7:0]  in_data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_status,
  output logic [1:0]  out_method_kind,
  output logic        out_is_http11,
  output logic        out_keep_alive,
  output logic [10:0] out_path_length,
  output logic        out_path_is_root,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic        item_valid;
  hrp_item_t   item;
  logic        item_take;
  logic        rq_full;
  logic        res_push;
  hrp_result_t res;
  hrp_result_t head;

  hrp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_op        (in_op),
    .in_data_byte (in_data_byte),
    .item_valid   (item_valid),
    .item         (item),
    .item_take    (item_take)
  );

  hrp_parser #(
    .HEADER_BUF_MAX (HEADER_BUF_MAX)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .rq_full    (rq_full),
    .res_push   (res_push),
    .res        (res)
  );

  hrp_rslt_q u_rslt_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .res      (res),
    .rq_full  (rq_full),
    .empty    (empty),
    .pop      (pop),
    .head     (head)
  );

  assign out_status       = head.status;
  assign out_method_kind  = head.method_kind;
  assign out_is_http11    = head.is_http11;
  assign out_keep_alive   = head.keep_conn;
  assign out_path_length  = head.path_length;
  assign out_path_is_root = head.path_is_root;

  a_too_large_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status == ST_TOO_LARGE) |->
      (!out_keep_alive && out_path_length == 11'd0 && out_method_kind == MK_GET))
    else $error("too-large result carries request fields");

  a_root_len: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_path_is_root) |-> (out_path_length == 11'd1 && out_status == ST_OK))
    else $error("root path flag without single-byte path");

  a_not_allowed_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status == ST_NOT_ALLOW) |->
      (out_method_kind == MK_OTHER && out_path_length == 11'd0))
    else $error("method-not-allowed result with wrong kind or path");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!full && empty))
    else $error("queues not empty after reset");

endmodule
